### design/bfish_pkg.sv
// ----------------------------------------------------------------------------
// bfish_pkg
// Shared types and constants of the Blowfish CBC cipher block.
// ----------------------------------------------------------------------------
`default_nettype none

package bfish_pkg;

    localparam int MaxKeyBytes = 56;
    localparam int NumSubkeys  = 18;
    localparam int NumRounds   = 16;
    localparam int BoxSize     = 256;
    localparam int NumBoxes    = 4;
    localparam int TableWords  = NumSubkeys + NumBoxes * BoxSize;
    // encryptions of the key schedule: P pairs first, then S pairs
    localparam int KsPBlocks   = NumSubkeys / 2;
    localparam int KsBlocks    = KsPBlocks + NumBoxes * BoxSize / 2;
    localparam int KeyXBytes   = NumSubkeys * 4;

    localparam int KeyAw  = $clog2(MaxKeyBytes);
    localparam int KeyLw  = 6;
    localparam int PAw    = $clog2(NumSubkeys);
    localparam int SAw    = $clog2(NumBoxes * BoxSize);
    localparam int BoxAw  = $clog2(BoxSize);
    localparam int BoxSw  = $clog2(NumBoxes);
    localparam int RndW   = $clog2(NumRounds);
    localparam int KsW    = $clog2(KsBlocks + 1);
    localparam int KcW    = $clog2(KeyXBytes + 1);
    localparam int IdxW   = 11;
    localparam int ActW   = 3;
    localparam int InDw   = 120;

    localparam logic [ActW-1:0] ACT_LOAD_TAB = 3'd0;
    localparam logic [ActW-1:0] ACT_LOAD_KEY = 3'd1;
    localparam logic [ActW-1:0] ACT_EXPAND   = 3'd2;
    localparam logic [ActW-1:0] ACT_ENCRYPT  = 3'd3;
    localparam logic [ActW-1:0] ACT_DECRYPT  = 3'd4;
    localparam logic [ActW-1:0] ACT_SET_IV   = 3'd5;

    localparam logic [0:0] REG_KEY_LEN = 1'b0;
    localparam logic [0:0] REG_CHAIN   = 1'b1;

    typedef struct packed {
        logic              ld_tab;
        logic              ld_key;
        logic              set_iv;
        logic              start_blk;
        logic              blk_clear;
        logic              rnd_go;
        logic              rnd_first;
        logic [PAw-1:0]    p_idx;
        logic              dec;
        logic              fin;
        logic              fin_out;
        logic              fin_ppair;
        logic [PAw-2:0]    p_pair;
        logic              fin_shi;
        logic              s_lo;
        logic [SAw-1:0]    s_idx;
        logic              key_rd;
        logic [KeyAw-1:0]  key_addr;
        logic              key_acc;
        logic              key_done;
        logic [PAw-1:0]    key_widx;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

### design/bfish_ctrl.sv
// ----------------------------------------------------------------------------
// bfish_ctrl
// Sequencer: item decode, round counter, key mixing and key schedule steps.
// ----------------------------------------------------------------------------
`default_nettype none

module bfish_ctrl
    import bfish_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire logic [ActW-1:0]  i_action,
    input  wire logic [KeyLw-1:0] i_key_len,
    input  wire t_sts             i_sts,
    output t_cmd                  o_cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_KEYX  = 3'd1;
    localparam logic [2:0] ST_ROUND = 3'd2;
    localparam logic [2:0] ST_FINAL = 3'd3;
    localparam logic [2:0] ST_SLO   = 3'd4;

    logic [2:0]       r_st, n_st;
    logic [RndW-1:0]  r_rnd, n_rnd;
    logic [KsW-1:0]   r_ksn, n_ksn;
    logic [KcW-1:0]   r_kc, n_kc;
    logic [KeyAw-1:0] r_pos, n_pos;
    logic             r_dec, n_dec;
    logic             r_ks, n_ks;
    logic             r_kv;
    logic [KcW-1:0]   r_kb;
    logic             acc;
    logic [KsW-1:0]   s_blk;
    logic [KeyAw:0]   pos_inc;

    assign o_ready = (r_st == ST_IDLE);
    assign acc     = i_valid && o_ready;
    assign s_blk   = r_ksn - KsW'(KsPBlocks);
    assign pos_inc = {1'b0, r_pos} + (KeyAw+1)'(1);

    always_comb begin
        n_st  = r_st;
        n_rnd = r_rnd;
        n_ksn = r_ksn;
        n_kc  = r_kc;
        n_pos = r_pos;
        n_dec = r_dec;
        n_ks  = r_ks;
        o_cmd = '0;
        o_cmd.dec       = r_dec;
        o_cmd.p_idx     = r_dec ? PAw'(NumSubkeys - 1) - PAw'(r_rnd) : PAw'(r_rnd);
        o_cmd.rnd_first = (r_rnd == '0);
        o_cmd.p_pair    = r_ksn[PAw-2:0];
        o_cmd.s_idx     = {s_blk[SAw-2:0], 1'b0};
        o_cmd.key_addr  = r_pos;
        o_cmd.key_acc   = r_kv;
        o_cmd.key_done  = r_kv && (r_kb[1:0] == 2'd3);
        o_cmd.key_widx  = r_kb[KcW-1:2];
        unique case (r_st)
            ST_IDLE: begin
                if (acc) begin
                    case (i_action)
                        ACT_LOAD_TAB: o_cmd.ld_tab = 1'b1;
                        ACT_LOAD_KEY: o_cmd.ld_key = 1'b1;
                        ACT_SET_IV:   o_cmd.set_iv = 1'b1;
                        ACT_EXPAND: begin
                            n_st  = ST_KEYX;
                            n_kc  = '0;
                            n_pos = '0;
                        end
                        ACT_ENCRYPT, ACT_DECRYPT: begin
                            o_cmd.start_blk = 1'b1;
                            // direction of the item being taken, not the last one
                            o_cmd.dec = (i_action == ACT_DECRYPT);
                            n_dec = (i_action == ACT_DECRYPT);
                            n_ks  = 1'b0;
                            n_rnd = '0;
                            n_st  = ST_ROUND;
                        end
                        default: ;
                    endcase
                end
            end
            ST_KEYX: begin
                if (r_kc == KcW'(KeyXBytes)) begin
                    o_cmd.blk_clear = 1'b1;
                    n_dec = 1'b0;
                    n_ks  = 1'b1;
                    n_ksn = '0;
                    n_rnd = '0;
                    n_st  = ST_ROUND;
                end else begin
                    o_cmd.key_rd = 1'b1;
                    n_kc  = r_kc + KcW'(1);
                    n_pos = (pos_inc >= {1'b0, i_key_len}) ? '0 : pos_inc[KeyAw-1:0];
                end
            end
            ST_ROUND: begin
                o_cmd.rnd_go = 1'b1;
                n_rnd = r_rnd + RndW'(1);
                if (r_rnd == RndW'(NumRounds - 1)) begin
                    n_st = ST_FINAL;
                end
            end
            ST_FINAL: begin
                if (r_ks) begin
                    o_cmd.fin = 1'b1;
                    if (r_ksn < KsW'(KsPBlocks)) begin
                        o_cmd.fin_ppair = 1'b1;
                        n_ksn = r_ksn + KsW'(1);
                        n_st  = ST_ROUND;
                    end else begin
                        o_cmd.fin_shi = 1'b1;
                        n_st = ST_SLO;
                    end
                end else if (i_sts.out_free) begin
                    o_cmd.fin     = 1'b1;
                    o_cmd.fin_out = 1'b1;
                    n_st = ST_IDLE;
                end
            end
            ST_SLO: begin
                o_cmd.s_lo = 1'b1;
                if (r_ksn == KsW'(KsBlocks - 1)) begin
                    n_st = ST_IDLE;
                end else begin
                    n_ksn = r_ksn + KsW'(1);
                    n_st  = ST_ROUND;
                end
            end
            default: n_st = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= ST_IDLE;
            r_rnd <= '0;
            r_ksn <= '0;
            r_kc  <= '0;
            r_pos <= '0;
            r_dec <= 1'b0;
            r_ks  <= 1'b0;
            r_kv  <= 1'b0;
            r_kb  <= '0;
        end else begin
            r_st  <= n_st;
            r_rnd <= n_rnd;
            r_ksn <= n_ksn;
            r_kc  <= n_kc;
            r_pos <= n_pos;
            r_dec <= n_dec;
            r_ks  <= n_ks;
            // key bytes come back in the cycle after the read
            r_kv  <= o_cmd.key_rd;
            r_kb  <= r_kc;
        end
    end

endmodule

`default_nettype wire

### design/bfish_dp.sv
// ----------------------------------------------------------------------------
// bfish_dp
// Datapath: P array, four S-box memories, key store, Feistel round, chaining.
// ----------------------------------------------------------------------------
`default_nettype none

module bfish_dp
    import bfish_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_cmd             i_cmd,
    input  wire logic             i_cbc,
    input  wire logic [IdxW-1:0]  i_index,
    input  wire logic [31:0]      i_table_word,
    input  wire logic [7:0]       i_key_byte,
    input  wire logic [63:0]      i_data_block,
    input  wire logic             i_out_ready,
    output t_sts                  o_sts,
    output logic                  o_out_valid,
    output logic [63:0]           o_result_block,
    output logic                  o_was_decrypt
);

    logic [31:0] r_p [NumSubkeys];
    logic [31:0] r_sbox [NumBoxes][BoxSize];
    logic [31:0] r_sdat [NumBoxes];
    logic [7:0]  r_key [MaxKeyBytes];
    logic [7:0]  r_kdat;
    logic [23:0] r_kw;
    logic [63:0] r_blk;
    logic [63:0] r_din;
    logic [63:0] r_chain;
    logic [31:0] r_hx;
    logic [31:0] r_lo;
    logic        r_ovalid;
    logic [63:0] r_odata;
    logic        r_odec;

    logic [31:0]       f;
    logic [31:0]       l_cur, r_cur, x;
    logic [31:0]       l16;
    logic [63:0]       res;
    logic [IdxW-1:0]   s_lin;
    logic              s_we;
    logic [BoxSw-1:0]  s_wbox;
    logic [BoxAw-1:0]  s_went;
    logic [31:0]       s_wdat;
    logic [31:0]       kword;

    assign f     = (r_sdat[0] + r_sdat[1]) ^ (r_sdat[2] + r_sdat[3]);
    assign l_cur = i_cmd.rnd_first ? r_blk[63:32] : (r_lo ^ f);
    assign r_cur = i_cmd.rnd_first ? r_blk[31:0] : r_hx;
    assign x     = l_cur ^ r_p[i_cmd.p_idx];
    assign l16   = r_lo ^ f;
    assign res   = i_cmd.dec ? {r_hx ^ r_p[0], l16 ^ r_p[1]}
                             : {r_hx ^ r_p[NumSubkeys-1], l16 ^ r_p[NumSubkeys-2]};
    assign s_lin = i_index - IdxW'(NumSubkeys);
    assign kword = {r_kw, r_kdat};

    // one write port on the S-boxes: table loads and key schedule stores
    always_comb begin
        s_we   = 1'b0;
        s_wbox = i_cmd.s_idx[SAw-1:BoxAw];
        s_went = i_cmd.s_idx[BoxAw-1:0];
        s_wdat = res[63:32];
        if (i_cmd.ld_tab) begin
            s_we   = (i_index >= IdxW'(NumSubkeys)) && (i_index < IdxW'(TableWords));
            s_wbox = s_lin[SAw-1:BoxAw];
            s_went = s_lin[BoxAw-1:0];
            s_wdat = i_table_word;
        end else if (i_cmd.fin_shi) begin
            s_we = 1'b1;
        end else if (i_cmd.s_lo) begin
            s_we   = 1'b1;
            s_went = {i_cmd.s_idx[BoxAw-1:1], 1'b1};
            s_wdat = r_blk[31:0];
        end
    end

    for (genvar b = 0; b < NumBoxes; b++) begin : g_box
        always_ff @(posedge i_clk) begin
            if (s_we && (s_wbox == BoxSw'(b))) begin
                r_sbox[b][s_went] <= s_wdat;
            end
            if (i_cmd.rnd_go) begin
                r_sdat[b] <= r_sbox[b][x[31-8*b -: 8]];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_key && (i_index < IdxW'(MaxKeyBytes))) begin
            r_key[i_index[KeyAw-1:0]] <= i_key_byte;
        end
        if (i_cmd.key_rd) begin
            r_kdat <= r_key[i_cmd.key_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_tab && (i_index < IdxW'(NumSubkeys))) begin
            r_p[i_index[PAw-1:0]] <= i_table_word;
        end
        if (i_cmd.key_done) begin
            r_p[i_cmd.key_widx] <= r_p[i_cmd.key_widx] ^ kword;
        end
        if (i_cmd.fin_ppair) begin
            r_p[{i_cmd.p_pair, 1'b0}] <= res[63:32];
            r_p[{i_cmd.p_pair, 1'b1}] <= res[31:0];
        end
        if (i_cmd.key_acc) begin
            r_kw <= kword[23:0];
        end
        if (i_cmd.rnd_go) begin
            r_hx <= x;
            r_lo <= r_cur;
        end
        if (i_cmd.start_blk) begin
            r_din <= i_data_block;
            // cbc encrypt folds the chaining value in before the rounds
            r_blk <= (i_cbc && !i_cmd.dec) ? (i_data_block ^ r_chain) : i_data_block;
        end
        if (i_cmd.blk_clear) begin
            r_blk <= '0;
        end
        if (i_cmd.fin) begin
            r_blk <= res;
        end
        if (i_cmd.fin_out) begin
            r_odata <= i_cmd.dec ? (res ^ (i_cbc ? r_chain : 64'd0)) : res;
            r_odec  <= i_cmd.dec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chain  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.set_iv) begin
                r_chain <= i_data_block;
            end else if (i_cmd.fin_out) begin
                r_chain <= i_cmd.dec ? r_din : res;
            end
            if (i_cmd.fin_out) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_sts.out_free = !r_ovalid || i_out_ready;
    assign o_out_valid    = r_ovalid;
    assign o_result_block = r_odata;
    assign o_was_decrypt  = r_odec;

endmodule

`default_nettype wire

### design/blowfish_cbc_cipher_top.sv
// ----------------------------------------------------------------------------
// blowfish_cbc_cipher_top
// Blowfish block cipher with optional CBC chaining and key schedule.
// ----------------------------------------------------------------------------
//  port group   dir  contents
//  s_axis_*     in   item: tuser = action, tdata = index/table_word/key_byte/data
//  m_axis_*     out  result: tdata = result_block, tuser = was_decrypt
//  apb          in   key_length at 0x0, chaining_enable at 0x4
//
//  encrypt/decrypt: accept cycle, 16 Feistel rounds on the S-box reads, then
//  whitening; no new item is taken until the result is registered.
//  expand key: key mixing, one key-store read a cycle, then 9 encryptions
//  for P and 512 for S, each S pair written by halves (one S-box write port).
//  reset is synchronous; load and IV items need no work state; s_axis_tready
//  drops while an item is at work; whitening waits while a result is unread.
// ----------------------------------------------------------------------------
`default_nettype none

module blowfish_cbc_cipher_top
    import bfish_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    // [10:0] index, [42:11] table_word, [50:43] key_byte, [114:51] data_block
    input  wire logic [InDw-1:0]   s_axis_tdata,
    // [2:0] action
    input  wire logic [ActW-1:0]   s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    // [63:0] result_block
    output logic [63:0]            m_axis_tdata,
    // [0] was_decrypt
    output logic [0:0]             m_axis_tuser,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [2:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    logic [KeyLw-1:0] r_key_len;
    logic             r_cbc;
    logic [KeyLw-1:0] len_eff;
    t_cmd             cmd;
    t_sts             sts;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_len <= KeyLw'(1);
            r_cbc     <= 1'b1;
        end else if (psel && penable && pwrite && pready) begin
            unique case (paddr[2])
                REG_KEY_LEN: r_key_len <= pwdata[KeyLw-1:0];
                REG_CHAIN:   r_cbc     <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_KEY_LEN: prdata = {{(32-KeyLw){1'b0}}, r_key_len};
            REG_CHAIN:   prdata = {31'd0, r_cbc};
            default:     prdata = '0;
        endcase
    end

    always_comb begin
        if (r_key_len == '0) begin
            len_eff = KeyLw'(1);
        end else if (r_key_len > KeyLw'(MaxKeyBytes)) begin
            len_eff = KeyLw'(MaxKeyBytes);
        end else begin
            len_eff = r_key_len;
        end
    end

    bfish_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_action  (s_axis_tuser),
        .i_key_len (len_eff),
        .i_sts     (sts),
        .o_cmd     (cmd)
    );

    bfish_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_cbc          (r_cbc),
        .i_index        (s_axis_tdata[10:0]),
        .i_table_word   (s_axis_tdata[42:11]),
        .i_key_byte     (s_axis_tdata[50:43]),
        .i_data_block   (s_axis_tdata[114:51]),
        .i_out_ready    (m_axis_tready),
        .o_sts          (sts),
        .o_out_valid    (m_axis_tvalid),
        .o_result_block (m_axis_tdata),
        .o_was_decrypt  (m_axis_tuser[0])
    );

endmodule

`default_nettype wire

### design/bfish_chk.sv
// ----------------------------------------------------------------------------
// bfish_chk
// Port-level checks of the cipher top level, bound onto every instance.
// ----------------------------------------------------------------------------
`default_nettype none

module bfish_chk
    import bfish_pkg::*;
(
    input wire logic            i_clk,
    input wire logic            i_rst_n,
    input wire logic            s_axis_tvalid,
    input wire logic            s_axis_tready,
    input wire logic [ActW-1:0] s_axis_tuser,
    input wire logic            m_axis_tvalid,
    input wire logic            m_axis_tready,
    input wire logic [63:0]     m_axis_tdata
);

    logic blk_acc;
    assign blk_acc = s_axis_tvalid && s_axis_tready &&
                     (s_axis_tuser == ACT_ENCRYPT || s_axis_tuser == ACT_DECRYPT);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result item dropped or changed while stalled");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        blk_acc |=> !s_axis_tready ##1 !s_axis_tready)
        else $error("input taken while a block is being ciphered");

    a_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
        else $error("result item without a block at work");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind blowfish_cbc_cipher_top bfish_chk u_bfish_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
